@@ hdl/double_ended_queue_core_assert.svh @@
// Assertion macros shared by the double-ended queue RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DQC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dqc assertion failed");

// Next-cycle implication, checked outside reset.
`define DQC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dqc assertion failed");

`endif

@@ hdl/dqc_pkg.sv @@
// Package for the double-ended queue: opcodes, status codes, FSM states and
// the command and result transaction structs. No dependencies.
`timescale 1ns / 1ps

package dqc_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} state_t;

	typedef struct packed {
		logic        [2:0]  opcode;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] word;
		logic        [1:0]  status;
		logic               last;
	} result_t;

endpackage

@@ hdl/double_ended_queue_core.sv @@
// Top level of the bounded double-ended queue: ring buffer in one RAM,
// head and occupancy registers, dump sequencer. Uses dqc_pkg, dqc_ram and
// double_ended_queue_core_assert.svh.
//
//   channel   signals                 transaction taken when
//   command   start, busy, cmd        start && !busy at a rising edge
//   result    strobe, result          strobe high; receiver cannot stall
//
// Push and pop may follow one another every cycle; their result appears the
// cycle after acceptance, once the RAM read returns. A dump holds busy after
// acceptance until its last word is read, one RAM read per stored word, and
// emits one result per cycle. Undefined opcodes are taken and give no result.
// Reset empties the queue; slot contents are not cleared.
`timescale 1ns / 1ps
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core #(
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  dqc_pkg::cmd_t    cmd,
	output logic             strobe,
	output dqc_pkg::result_t result
);

	import dqc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] occ_q, occ_d;
	logic [CW-1:0] cnt_q, cnt_d;

	logic          rsp_v_s1, rsp_v_d;
	status_t       rsp_st_s1, rsp_st_d;
	logic          rsp_last_s1, rsp_last_d;
	logic          rsp_mem_s1, rsp_mem_d;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;

	logic          accept, is_full, is_empty;
	op_t           op;
	logic [CW-1:0] offset;
	logic [SW-1:0] sum;
	logic [AW-1:0] wrap_idx, head_dec, head_inc;

	assign accept   = start && !busy;
	assign op       = op_t'(cmd.opcode);
	assign is_full  = (occ_q == DEPTH_C);
	assign is_empty = (occ_q == '0);
	assign busy     = (state_q == S_DUMP);

	// Offset from the head for the one slot touched this cycle.
	always_comb begin
		offset = '0;
		if (state_q == S_DUMP) begin
			offset = cnt_q;
		end else begin
			case (op)
				OP_PUSH_REAR: offset = occ_q;
				OP_POP_REAR:  offset = occ_q - 1'b1;
				default:      offset = '0;
			endcase
		end
	end

	// Head plus offset stays below twice the depth, so one subtract wraps it.
	assign sum      = SW'(head_q) + SW'(offset);
	assign wrap_idx = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		occ_d      = occ_q;
		cnt_d      = cnt_q;
		ram_we     = 1'b0;
		ram_waddr  = wrap_idx;
		ram_re     = 1'b0;
		ram_raddr  = wrap_idx;
		rsp_v_d    = 1'b0;
		rsp_st_d   = ST_OK;
		rsp_last_d = 1'b1;
		rsp_mem_d  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUSH_FRONT: begin
							rsp_v_d = 1'b1;
							if (is_full) begin
								rsp_st_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = head_dec;
								head_d    = head_dec;
								occ_d     = occ_q + 1'b1;
							end
						end
						OP_PUSH_REAR: begin
							rsp_v_d = 1'b1;
							if (is_full) begin
								rsp_st_d = ST_FULL;
							end else begin
								ram_we = 1'b1;
								occ_d  = occ_q + 1'b1;
							end
						end
						OP_POP_FRONT: begin
							rsp_v_d = 1'b1;
							if (is_empty) begin
								rsp_st_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = head_q;
								rsp_mem_d = 1'b1;
								head_d    = head_inc;
								occ_d     = occ_q - 1'b1;
							end
						end
						OP_POP_REAR: begin
							rsp_v_d = 1'b1;
							if (is_empty) begin
								rsp_st_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								rsp_mem_d = 1'b1;
								occ_d     = occ_q - 1'b1;
							end
						end
						OP_DUMP: begin
							rsp_v_d = 1'b1;
							if (is_empty) begin
								rsp_st_d = ST_EMPTY;
							end else begin
								ram_re     = 1'b1;
								rsp_mem_d  = 1'b1;
								rsp_last_d = (occ_q == CW'(1));
								cnt_d      = CW'(1);
								if (occ_q != CW'(1)) begin
									state_d = S_DUMP;
								end
							end
						end
						default: ;
					endcase
				end
			end
			S_DUMP: begin
				ram_re     = 1'b1;
				rsp_v_d    = 1'b1;
				rsp_mem_d  = 1'b1;
				rsp_last_d = (cnt_q == occ_q - 1'b1);
				cnt_d      = cnt_q + 1'b1;
				if (rsp_last_d) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			occ_q    <= '0;
			cnt_q    <= '0;
			rsp_v_s1 <= 1'b0;
		end else begin
			head_q   <= head_d;
			occ_q    <= occ_d;
			cnt_q    <= cnt_d;
			rsp_v_s1 <= rsp_v_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_st_s1   <= rsp_st_d;
		rsp_last_s1 <= rsp_last_d;
		rsp_mem_s1  <= rsp_mem_d;
	end

	dqc_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd.value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign strobe        = rsp_v_s1;
	assign result.word   = rsp_mem_s1 ? ram_rdata : '0;
	assign result.status = rsp_st_s1;
	assign result.last   = rsp_last_s1;

	`DQC_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= DEPTH_C)
	`DQC_ASSERT_IMP(a_dump_cnt, state_q == S_DUMP, cnt_q != '0 && cnt_q < occ_q)
	`DQC_ASSERT_NXT(a_dump_holds_occ, state_q == S_DUMP, $stable(occ_q) && $stable(head_q))
	`DQC_ASSERT_IMP(a_no_write_full, ram_we, !is_full && !ram_re)
	`DQC_ASSERT_NXT(a_full_flag, accept && is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR), strobe && result.status == ST_FULL && result.word == '0)

endmodule

@@ hdl/dqc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module dqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the double-ended queue core: random and directed
// push, pop and dump traffic, predicted by a ring-buffer model of the queue.
// Depends on dqc_pkg and double_ended_queue_core.
`timescale 1ns / 1ps

module tb_top;
	import dqc_pkg::*;

	localparam int DEPTH        = 32;
	localparam int RANDOM_ITEMS = 460;
	localparam int STALL_LIMIT  = 2000;

	typedef struct {
		cmd_t        txn;
		int unsigned gap_pct;
	} cmd_slot_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    strobe;
	result_t result;

	cmd_slot_t cmd_backlog[$];
	result_t   pending_results[$];

	// Predicted queue contents.
	logic signed [31:0] ring [DEPTH];
	int                 head_pos;
	int                 fill_count;

	logic taken;
	int   error_count;
	int   quiet_cycles;

	double_ended_queue_core #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic expect_result(input logic signed [31:0] w, input status_t st,
			input logic lst);
		result_t r;
		r.word   = w;
		r.status = st;
		r.last   = lst;
		pending_results.push_back(r);
	endtask

	// Applies one accepted command transaction to the predicted queue.
	task automatic deque_apply(input cmd_t c);
		int i;
		case (c.opcode)
			OP_PUSH_FRONT: begin
				if (fill_count >= DEPTH) begin
					expect_result(0, ST_FULL, 1'b1);
				end else begin
					head_pos = (head_pos + DEPTH - 1) % DEPTH;
					ring[head_pos] = c.value;
					fill_count++;
					expect_result(0, ST_OK, 1'b1);
				end
			end
			OP_PUSH_REAR: begin
				if (fill_count >= DEPTH) begin
					expect_result(0, ST_FULL, 1'b1);
				end else begin
					ring[(head_pos + fill_count) % DEPTH] = c.value;
					fill_count++;
					expect_result(0, ST_OK, 1'b1);
				end
			end
			OP_POP_FRONT: begin
				if (fill_count == 0) begin
					expect_result(0, ST_EMPTY, 1'b1);
				end else begin
					expect_result(ring[head_pos], ST_OK, 1'b1);
					head_pos = (head_pos + 1) % DEPTH;
					fill_count--;
				end
			end
			OP_POP_REAR: begin
				if (fill_count == 0) begin
					expect_result(0, ST_EMPTY, 1'b1);
				end else begin
					expect_result(ring[(head_pos + fill_count - 1) % DEPTH], ST_OK, 1'b1);
					fill_count--;
				end
			end
			OP_DUMP: begin
				if (fill_count == 0) begin
					expect_result(0, ST_EMPTY, 1'b1);
				end else begin
					for (i = 0; i < fill_count; i++)
						expect_result(ring[(head_pos + i) % DEPTH], ST_OK,
							i == fill_count - 1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] v,
			input int unsigned gap);
		cmd_slot_t s;
		s.txn.opcode = op;
		s.txn.value  = v;
		s.gap_pct    = gap;
		cmd_backlog.push_back(s);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return $urandom_range(15);
			3:       return -$signed({1'b0, 4'($urandom_range(15))});
			default: return $urandom();
		endcase
	endfunction

	// Driver: offers the next transaction once the previous one was taken.
	always @(negedge clk) begin
		cmd_slot_t nxt;
		if (arst_n && (!start || taken)) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= cmd_backlog[0].gap_pct) begin
				nxt = cmd_backlog.pop_front();
				cmd <= nxt.txn;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks results against the oldest prediction, then records
	// any command accepted at this edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (pending_results.size() == 0) begin
					flag_error($sformatf("unexpected result word=%0d status=%0d last=%0b",
						result.word, result.status, result.last));
				end else begin
					want = pending_results.pop_front();
					if (result.word !== want.word)
						flag_error($sformatf("word %0d, expected %0d",
							result.word, want.word));
					if (result.status !== want.status)
						flag_error($sformatf("status %0d, expected %0d",
							result.status, want.status));
					if (result.last !== want.last)
						flag_error($sformatf("last %0b, expected %0b",
							result.last, want.last));
				end
			end
			taken = start && !busy;
			if (taken)
				deque_apply(cmd);
		end else begin
			taken = 1'b0;
		end
	end

	// Watchdog on cycles with neither a command nor a result transaction.
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int          issued;
		int          mode;
		int          burst;
		int          push_pct;
		int unsigned gap;
		int unsigned roll;
		logic [2:0]  op;

		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		taken        = 1'b0;
		error_count  = 0;
		quiet_cycles = 0;
		head_pos     = 0;
		fill_count   = 0;

		// Directed: empty cases, extreme words, unused opcodes, both ends.
		add_cmd(OP_POP_FRONT, 0, 0);
		add_cmd(OP_POP_REAR, 0, 0);
		add_cmd(OP_DUMP, 0, 0);
		add_cmd(OP_PUSH_FRONT, 32'sh7fffffff, 0);
		add_cmd(OP_PUSH_REAR, 32'sh80000000, 0);
		add_cmd(OP_PUSH_FRONT, -1, 0);
		add_cmd(OP_PUSH_REAR, 0, 0);
		add_cmd(OP_DUMP, 32'sh5a5a5a5a, 0);
		add_cmd(3'd5, 32'sh12345678, 0);
		add_cmd(3'd6, -1, 0);
		add_cmd(3'd7, 32'sh80000000, 0);
		add_cmd(OP_POP_REAR, -1, 0);
		add_cmd(OP_POP_FRONT, 0, 0);
		add_cmd(OP_DUMP, 0, 0);
		add_cmd(OP_POP_FRONT, 0, 0);
		add_cmd(OP_POP_REAR, 0, 0);
		add_cmd(OP_POP_FRONT, 0, 0);
		add_cmd(OP_PUSH_REAR, 1, 0);
		add_cmd(OP_DUMP, 0, 0);
		add_cmd(OP_POP_REAR, 0, 0);

		// Fill past full from both ends, dump the full queue, drain past empty.
		issued = 0;
		repeat (DEPTH + 2) begin
			add_cmd($urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT, rand_word(), 0);
			issued++;
		end
		add_cmd(OP_DUMP, rand_word(), 0);
		repeat (DEPTH + 2) begin
			add_cmd($urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT, rand_word(), 0);
			issued++;
		end
		issued++;

		// Bursts biased toward filling, draining or balanced traffic.
		while (issued < RANDOM_ITEMS) begin
			mode  = $urandom_range(2);
			burst = $urandom_range(20, 60);
			case ($urandom_range(2))
				0:       gap = 0;
				1:       gap = 47;
				default: gap = 33;
			endcase
			push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			repeat (burst) begin
				roll = $urandom_range(99);
				if (roll < 3)
					op = 3'($urandom_range(5, 7));
				else if (roll < 8)
					op = OP_DUMP;
				else if ($urandom_range(99) < push_pct)
					op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
				else
					op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
				add_cmd(op, rand_word(), gap);
				if (op <= OP_DUMP)
					issued++;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		@(negedge clk);
		while (cmd_backlog.size() != 0 || start || pending_results.size() != 0)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
